FILE: rtl/core/fircv_pkg.sv
// ----------------------------------------------------------------------------
// fircv_pkg
// Shared codes, widths and the control and status structs used between the
// FIR convolution sequencer and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fircv_pkg;

   localparam int FUNC_W  = 2;
   localparam int IDX_W   = 4;
   localparam int VALUE_W = 16;
   localparam int PROD_W  = 32;
   localparam int FILT_W  = 36;
   localparam int TAPS_W  = 5;

   localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

   localparam logic [TAPS_W-1:0] TAPS_RESET = 5'd16;

   // load index reaches this many coefficient slots at most
   localparam int IDX_SPAN = 16;
   // largest tap count the register can express
   localparam int TAPS_SPAN = 31;

   typedef struct packed {
      logic              load;
      logic              latch;
      logic              latch_zero;
      logic              mac;
      logic              first;
      logic [TAPS_W-1:0] tap;
      logic              commit;
      logic              last;
      logic              clear_dl;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/core/fir_full_convolution.sv
// ----------------------------------------------------------------------------
// fir_full_convolution
// Streaming direct-form FIR filter giving the full linear convolution of a
// Q4.11 sample stream with up to MAX_TAPS Q4.11 coefficients, Q13.22 output.
// ----------------------------------------------------------------------------
// A load item writes one coefficient. A sample item steps through n taps, n
// being the effective tap count (taps_in_use, with 0 read as 1 and values
// above MAX_TAPS read as MAX_TAPS): one signed 16x16 multiplier is shared by
// all taps, one tap per cycle, followed by an accumulate step and a commit
// step that waits for a free output register. A flush item produces n - 1
// tail results and clears the delay line; with one tap it produces nothing.
// Items are taken one at a time; a finished result waits in the output
// register while the next item is accepted. After reset the coefficients and
// delay line are zero and the block is ready at once.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_full_convolution #(
   parameter int MAX_TAPS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic        [fircv_pkg::FUNC_W-1:0]   req_func,
   input  wire logic        [fircv_pkg::IDX_W-1:0]    req_tap_index,
   input  wire logic signed [fircv_pkg::VALUE_W-1:0]  req_value,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed      [fircv_pkg::FILT_W-1:0]   rsp_filtered,
   output logic                                       rsp_last,
   input  wire logic                                  csr_wr_en,
   input  wire logic        [fircv_pkg::TAPS_W-1:0]   csr_wr_data
);

   fircv_pkg::cmd_type    cmd;
   fircv_pkg::status_type status;

   fircv_ctrl #(
      .MAX_TAPS (MAX_TAPS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_func    (req_func),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .status      (status),
      .cmd         (cmd)
   );

   fircv_dp #(
      .MAX_TAPS (MAX_TAPS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_tap_index (req_tap_index),
      .req_value     (req_value),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_filtered  (rsp_filtered),
      .rsp_last      (rsp_last)
   );

`ifndef SYNTHESIS
   // a result is only committed into a free output register
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("commit into an occupied output register");

   // no item is taken while the multiplier is stepping through taps
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.mac |-> !req_ready)
      else $error("input accepted during accumulation");

   // a commit shows up as a valid result in the next cycle
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("committed result not presented");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/fircv_ctrl.sv
// ----------------------------------------------------------------------------
// fircv_ctrl
// Sequencer: decodes items, steps the shared multiply-accumulate over the
// taps and issues commit, shift and flush commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module fircv_ctrl #(
   parameter int MAX_TAPS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [fircv_pkg::FUNC_W-1:0]  req_func,
   input  wire logic                          csr_wr_en,
   input  wire logic [fircv_pkg::TAPS_W-1:0]  csr_wr_data,
   input  fircv_pkg::status_type              status,
   output fircv_pkg::cmd_type                 cmd
);

   localparam int EFF_MAX = (MAX_TAPS < fircv_pkg::TAPS_SPAN) ? MAX_TAPS
                                                             : fircv_pkg::TAPS_SPAN;
   localparam logic [fircv_pkg::TAPS_W-1:0] EFF_MAX_V = fircv_pkg::TAPS_W'(EFF_MAX);
   localparam logic [fircv_pkg::TAPS_W-1:0] ONE_V     = fircv_pkg::TAPS_W'(1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MAC    = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type                      state_ff, state_in;
   logic [fircv_pkg::TAPS_W-1:0]   taps_ff;
   logic [fircv_pkg::TAPS_W-1:0]   tap_ff, tap_in;
   logic [fircv_pkg::TAPS_W-1:0]   cnt_ff, cnt_in;
   logic                           flush_ff, flush_in;
   logic [fircv_pkg::TAPS_W-1:0]   eff;
   logic [fircv_pkg::TAPS_W-1:0]   tail;
   logic                           final_out;

   always_comb begin
      if (taps_ff == '0) begin
         eff = ONE_V;
      end else if (taps_ff > EFF_MAX_V) begin
         eff = EFF_MAX_V;
      end else begin
         eff = taps_ff;
      end
   end

   assign tail      = eff - ONE_V;
   assign final_out = (cnt_ff + ONE_V) == tail;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      tap_in   = tap_ff;
      cnt_in   = cnt_ff;
      flush_in = flush_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_func)
                  fircv_pkg::FUNC_LOAD: begin
                     cmd.load = 1'b1;
                  end
                  fircv_pkg::FUNC_SAMPLE: begin
                     cmd.latch = 1'b1;
                     flush_in  = 1'b0;
                     tap_in    = '0;
                     state_in  = ST_MAC;
                  end
                  fircv_pkg::FUNC_FLUSH: begin
                     if (eff == ONE_V) begin
                        cmd.clear_dl = 1'b1;
                     end else begin
                        cmd.latch      = 1'b1;
                        cmd.latch_zero = 1'b1;
                        flush_in       = 1'b1;
                        cnt_in         = '0;
                        tap_in         = '0;
                        state_in       = ST_MAC;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MAC: begin
            cmd.mac   = 1'b1;
            cmd.first = (tap_ff == '0);
            cmd.tap   = tap_ff;
            if (tap_ff == tail) begin
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_ff + ONE_V;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               cmd.last   = flush_ff && final_out;
               if (flush_ff && !final_out) begin
                  cnt_in   = cnt_ff + ONE_V;
                  tap_in   = '0;
                  state_in = ST_MAC;
               end else begin
                  cmd.clear_dl = flush_ff;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         taps_ff  <= fircv_pkg::TAPS_RESET;
         tap_ff   <= '0;
         cnt_ff   <= '0;
         flush_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
         cnt_ff   <= cnt_in;
         flush_ff <= flush_in;
         if (csr_wr_en) begin
            taps_ff <= csr_wr_data;
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/fircv_dp.sv
// ----------------------------------------------------------------------------
// fircv_dp
// Datapath: coefficient store, delay line, shared multiplier with product
// register, accumulator and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fircv_dp #(
   parameter int MAX_TAPS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic        [fircv_pkg::IDX_W-1:0]    req_tap_index,
   input  wire logic signed [fircv_pkg::VALUE_W-1:0]  req_value,
   input  fircv_pkg::cmd_type                         cmd,
   output fircv_pkg::status_type                      status,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed      [fircv_pkg::FILT_W-1:0]   rsp_filtered,
   output logic                                       rsp_last
);

   localparam int EFF_MAX = (MAX_TAPS < fircv_pkg::TAPS_SPAN) ? MAX_TAPS
                                                             : fircv_pkg::TAPS_SPAN;
   localparam int CF_LEN  = (MAX_TAPS < fircv_pkg::IDX_SPAN) ? MAX_TAPS
                                                            : fircv_pkg::IDX_SPAN;
   localparam int DL_LEN  = (EFF_MAX > 1) ? EFF_MAX - 1 : 1;
   localparam int CF_AW   = (CF_LEN > 1) ? $clog2(CF_LEN) : 1;
   localparam int DL_AW   = (DL_LEN > 1) ? $clog2(DL_LEN) : 1;
   localparam logic [fircv_pkg::TAPS_W-1:0] CF_LEN_V = fircv_pkg::TAPS_W'(CF_LEN);
   localparam logic [fircv_pkg::TAPS_W-1:0] ONE_V    = fircv_pkg::TAPS_W'(1);

   logic signed [fircv_pkg::VALUE_W-1:0] coef_ff [CF_LEN];
   logic signed [fircv_pkg::VALUE_W-1:0] dl_ff   [DL_LEN];
   logic signed [fircv_pkg::VALUE_W-1:0] x0_ff;
   logic signed [fircv_pkg::PROD_W-1:0]  prod_ff;
   logic                                 prod_valid_ff;
   logic                                 prod_first_ff;
   logic signed [fircv_pkg::FILT_W-1:0]  acc_ff;
   logic signed [fircv_pkg::FILT_W-1:0]  filtered_ff;
   logic                                 last_ff;
   logic                                 rsp_valid_ff;

   logic signed [fircv_pkg::VALUE_W-1:0] x_sel;
   logic signed [fircv_pkg::VALUE_W-1:0] c_sel;
   logic        [fircv_pkg::TAPS_W-1:0]  dl_addr;
   logic                                 load_hit;

   assign dl_addr  = cmd.tap - ONE_V;
   assign x_sel    = (cmd.tap == '0) ? x0_ff : dl_ff[dl_addr[DL_AW-1:0]];
   assign c_sel    = (cmd.tap < CF_LEN_V) ? coef_ff[cmd.tap[CF_AW-1:0]] : '0;
   assign load_hit = ({1'b0, req_tap_index} < CF_LEN_V);

   // coefficient store and delay line
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CF_LEN; i++) begin
            coef_ff[i] <= '0;
         end
         for (int i = 0; i < DL_LEN; i++) begin
            dl_ff[i] <= '0;
         end
      end else begin
         if (cmd.load && load_hit) begin
            coef_ff[req_tap_index[CF_AW-1:0]] <= req_value;
         end
         if (cmd.clear_dl) begin
            for (int i = 0; i < DL_LEN; i++) begin
               dl_ff[i] <= '0;
            end
         end else if (cmd.commit) begin
            dl_ff[0] <= x0_ff;
            for (int i = 1; i < DL_LEN; i++) begin
               dl_ff[i] <= dl_ff[i-1];
            end
         end
      end
   end

   // multiply then accumulate
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         x0_ff <= cmd.latch_zero ? '0 : req_value;
      end
      prod_ff       <= fircv_pkg::PROD_W'(x_sel) * fircv_pkg::PROD_W'(c_sel);
      prod_first_ff <= cmd.first;
      if (prod_valid_ff) begin
         acc_ff <= (prod_first_ff ? '0 : acc_ff) + fircv_pkg::FILT_W'(prod_ff);
      end
      if (cmd.commit) begin
         filtered_ff <= acc_ff;
         last_ff     <= cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= cmd.mac;
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_filtered    = filtered_ff;
   assign rsp_last        = last_ff;

endmodule

`default_nettype wire
